// ----- rtl/config_field_extractor_assert.svh -----
// ----------------------------------------------------------------------------
// config_field_extractor_assert.svh
// Assertion macros used by the field extractor checker.
// ----------------------------------------------------------------------------
`ifndef CONFIG_FIELD_EXTRACTOR_ASSERT_SVH
`define CONFIG_FIELD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CFE_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CFE_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cfe_pkg.sv -----
// ----------------------------------------------------------------------------
// cfe_pkg
// Types and constants of the configuration field extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package cfe_pkg;

    // Output cap on characters of one field
    localparam int FIELD_MAX_DEFAULT = 128;

    localparam logic [7:0]  CHAR_SEMI    = 8'h3B;
    localparam logic [7:0]  CHAR_FF      = 8'hFF;
    localparam logic [7:0]  CHAR_A4      = 8'hA4;
    localparam logic [7:0]  CHAR_NUL     = 8'h00;
    localparam logic [23:0] DIP_WORD     = 24'h444950;
    localparam logic [1:0]  PREFIX_FULL  = 2'd3;

    typedef enum logic [2:0] {
        KIND_NONE       = 3'd0,
        KIND_CHAR       = 3'd1,
        KIND_FIELD_END  = 3'd2,
        KIND_DISCARD    = 3'd3,
        KIND_NO_CONFIG  = 3'd4,
        KIND_STREAM_END = 3'd5
    } kind_t;

    // Parser state carried from byte to byte
    typedef struct packed {
        logic [7:0]  field_number;
        logic [7:0]  chars_sent;
        logic [23:0] prefix_letters;
        logic [1:0]  prefix_count;
        logic        in_snippet;
        logic        finished;
        logic        awaiting_first;
    } state_t;

    // One result
    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       snippet;
    } result_t;

    localparam state_t STATE_CLEAR = '{
        field_number:   8'd0,
        chars_sent:     8'd0,
        prefix_letters: 24'd0,
        prefix_count:   2'd0,
        in_snippet:     1'b0,
        finished:       1'b0,
        awaiting_first: 1'b1
    };

endpackage

`default_nettype wire

// ----- rtl/cfe_ifs.sv -----
// ----------------------------------------------------------------------------
// cfe_ifs
// Valid/ready channels of the field extractor: byte requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfe_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       query_start;

    modport source (output valid, output char_in, output query_start, input ready);
    modport sink   (input valid, input char_in, input query_start, output ready);
endinterface

interface cfe_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] result_kind;
    logic [7:0] char_out;
    logic       next_from_snippet;

    modport source (output valid, output result_kind, output char_out,
                    output next_from_snippet, input ready);
    modport sink   (input valid, input result_kind, input char_out,
                    input next_from_snippet, output ready);
endinterface

`default_nettype wire

// ----- rtl/cfe_parser.sv -----
// ----------------------------------------------------------------------------
// cfe_parser
// Single-byte parse step: next parser state and the result for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cfe_parser #(
    parameter int FIELD_MAX = cfe_pkg::FIELD_MAX_DEFAULT
) (
    input  wire logic [7:0]      wanted_field,
    input  wire logic [7:0]      char_in,
    input  wire logic            query_start,
    input  wire cfe_pkg::state_t state_cur,
    output cfe_pkg::state_t      state_next,
    output cfe_pkg::result_t     result
);

    localparam logic [7:0] CAP = 8'(FIELD_MAX);

    cfe_pkg::state_t s;
    cfe_pkg::state_t n;
    cfe_pkg::kind_t  kind;
    logic [7:0]      ch;
    logic            is_dip;
    logic            wanted;

    always_comb
    begin
        // a new query clears the state before the byte is taken
        s      = query_start ? cfe_pkg::STATE_CLEAR : state_cur;
        n      = s;
        kind   = cfe_pkg::KIND_NONE;
        ch     = 8'd0;
        wanted = (s.field_number == wanted_field);
        is_dip = !s.in_snippet && (s.prefix_count == cfe_pkg::PREFIX_FULL)
                 && (s.prefix_letters == cfe_pkg::DIP_WORD);

        if (!s.finished)
        begin
            n.awaiting_first = 1'b0;
            if (s.awaiting_first &&
                (char_in == cfe_pkg::CHAR_FF || char_in == cfe_pkg::CHAR_A4))
            begin
                kind         = cfe_pkg::KIND_NO_CONFIG;
                n.finished   = 1'b1;
                n.in_snippet = 1'b0;
            end
            else if (s.chars_sent >= CAP || char_in == cfe_pkg::CHAR_FF)
            begin
                kind         = cfe_pkg::KIND_STREAM_END;
                n.finished   = 1'b1;
                n.in_snippet = 1'b0;
            end
            else if (char_in == cfe_pkg::CHAR_NUL)
            begin
                // zero in the snippet returns to the main stream
                if (s.in_snippet)
                begin
                    n.in_snippet = 1'b0;
                end
                else
                begin
                    kind         = cfe_pkg::KIND_STREAM_END;
                    n.finished   = 1'b1;
                    n.in_snippet = 1'b0;
                end
            end
            else if (char_in == cfe_pkg::CHAR_SEMI)
            begin
                n.prefix_count   = 2'd0;
                n.prefix_letters = 24'd0;
                if (is_dip)
                begin
                    n.in_snippet = 1'b1;
                    if (wanted)
                    begin
                        n.chars_sent = 8'd0;
                        kind         = cfe_pkg::KIND_DISCARD;
                    end
                end
                else if (wanted)
                begin
                    kind         = cfe_pkg::KIND_FIELD_END;
                    n.finished   = 1'b1;
                    n.in_snippet = 1'b0;
                end
                else
                begin
                    n.field_number = s.field_number + 8'd1;
                end
            end
            else
            begin
                // ordinary character: collect prefix, pass it on if wanted
                if (s.prefix_count != cfe_pkg::PREFIX_FULL)
                begin
                    n.prefix_letters = {s.prefix_letters[15:0], char_in};
                    n.prefix_count   = s.prefix_count + 2'd1;
                end
                if (wanted)
                begin
                    n.chars_sent = s.chars_sent + 8'd1;
                    kind         = cfe_pkg::KIND_CHAR;
                    ch           = char_in;
                end
            end
        end

        state_next     = n;
        result.kind    = kind;
        result.ch      = ch;
        result.snippet = n.in_snippet;
    end

endmodule

`default_nettype wire

// ----- rtl/config_field_extractor.sv -----
// ----------------------------------------------------------------------------
// config_field_extractor
// Picks one field out of a semicolon-separated configuration byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   src carries one request per byte: char_in and query_start (set on the
//   first byte of a query). res returns exactly one result per request:
//   result_kind, char_out and next_from_snippet, which tells the feeder
//   which source the next byte must come from.
//   cfg_we/cfg_wdata write the wanted field number; write only while idle.
//   A request accepted on src lands in the input register; the parse step
//   then writes its result into the result register, which offers it on
//   res. A stalled res holds the request in the input register.
//   Throughput: one byte per cycle while res does not stall; the parse
//   step between the input and result registers closes the state loop.
//   Reset clears the parser state (next byte starts a query) and sets the
//   wanted field to 0.
//   When res stalls, the result register holds; the input register still
//   takes one more request, then src.ready drops until res drains.
// ----------------------------------------------------------------------------
`default_nettype none

module config_field_extractor #(
    parameter int FIELD_MAX = cfe_pkg::FIELD_MAX_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    cfe_char_if.sink        src,
    cfe_result_if.source    res
);

    logic [7:0]       wanted_field_reg;
    logic             in_valid_reg;
    logic [7:0]       in_char_reg;
    logic             in_qs_reg;
    cfe_pkg::state_t  state_reg;
    cfe_pkg::state_t  state_next;
    cfe_pkg::result_t result_next;
    cfe_pkg::result_t result_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             in_take;

    // parse step moves when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || res.ready);
    assign src.ready = !in_valid_reg || advance;
    assign in_take = src.valid && src.ready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wanted_field_reg <= 8'd0;
        else if (cfg_we)
            wanted_field_reg <= cfg_wdata;
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= src.char_in;
            in_qs_reg   <= src.query_start;
        end
    end

    cfe_parser #(
        .FIELD_MAX (FIELD_MAX)
    ) u_parser (
        .wanted_field (wanted_field_reg),
        .char_in      (in_char_reg),
        .query_start  (in_qs_reg),
        .state_cur    (state_reg),
        .state_next   (state_next),
        .result       (result_next)
    );

    // parser state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfe_pkg::STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign res.valid             = out_valid_reg;
    assign res.result_kind       = result_reg.kind;
    assign res.char_out          = result_reg.ch;
    assign res.next_from_snippet = result_reg.snippet;

endmodule

`default_nettype wire

// ----- rtl/cfe_checker.sv -----
// ----------------------------------------------------------------------------
// cfe_checker
// Port-level checks of the field extractor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "config_field_extractor_assert.svh"

module cfe_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] result_kind,
    input wire logic [7:0] char_out,
    input wire logic       next_from_snippet
);

    logic kind_ends;

    // results that close a query
    assign kind_ends = (result_kind == cfe_pkg::KIND_FIELD_END) ||
                       (result_kind == cfe_pkg::KIND_NO_CONFIG) ||
                       (result_kind == cfe_pkg::KIND_STREAM_END);

    `CFE_ASSERT_NOW(a_char_only_on_char, clk, rst_n, out_valid && result_kind != cfe_pkg::KIND_CHAR, char_out == 8'd0, "char_out set on a non-character result")
    `CFE_ASSERT_NOW(a_end_main_stream, clk, rst_n, out_valid && kind_ends, !next_from_snippet, "query end still requests snippet")
    `CFE_ASSERT_NOW(a_kind_legal, clk, rst_n, out_valid, result_kind <= cfe_pkg::KIND_STREAM_END, "undefined result kind")
    `CFE_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(char_out), "stalled result changed")

endmodule

bind config_field_extractor cfe_checker u_cfe_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (res.valid),
    .out_ready         (res.ready),
    .result_kind       (res.result_kind),
    .char_out          (res.char_out),
    .next_from_snippet (res.next_from_snippet)
);

`default_nettype wire

// ----- sim/config_field_extractor_tb.sv -----
// ----------------------------------------------------------------------------
// config_field_extractor_tb
// Self-checking bench for the configuration field extractor. Config strings
// are built from random fields: DIP lines with spliced snippets, empty and
// over-long fields, missing terminators, no-config markers and raw noise.
// A parser model in the bench predicts one result per accepted request, and
// the monitor compares each result, field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module config_field_extractor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cfe_pkg::*;

    localparam int CHAR_CAP    = FIELD_MAX_DEFAULT;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } char_req_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    cfe_char_if   src_if ();
    cfe_result_if res_if ();

    config_field_extractor #(
        .FIELD_MAX (CHAR_CAP)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .src       (src_if),
        .res       (res_if)
    );

    char_req_t  char_reqs[$];
    result_t    pending_results[$];
    state_t     parser;
    logic [7:0] wanted_shadow;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         err_count;
    int         queued_count;
    bit         next_is_first;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Parser model: one request in, one result out
    function automatic result_t parse_byte(input logic [7:0] b, input logic first_req);
        result_t r;
        logic    was_first;
        logic    ends_query;
        logic    dip_line;
        r          = '{kind: KIND_NONE, ch: 8'd0, snippet: 1'b0};
        ends_query = 1'b0;
        if (first_req)
            parser = STATE_CLEAR;
        if (!parser.finished)
        begin
            was_first             = parser.awaiting_first;
            parser.awaiting_first = 1'b0;
            if (was_first && (b == CHAR_FF || b == CHAR_A4))
            begin
                r.kind     = KIND_NO_CONFIG;
                ends_query = 1'b1;
            end
            else if (int'(parser.chars_sent) >= CHAR_CAP || b == CHAR_FF)
            begin
                r.kind     = KIND_STREAM_END;
                ends_query = 1'b1;
            end
            else if (b == CHAR_NUL)
            begin
                // zero from the snippet returns to the main string
                if (parser.in_snippet)
                    parser.in_snippet = 1'b0;
                else
                begin
                    r.kind     = KIND_STREAM_END;
                    ends_query = 1'b1;
                end
            end
            else if (b == CHAR_SEMI)
            begin
                dip_line = !parser.in_snippet && parser.prefix_count == PREFIX_FULL &&
                           parser.prefix_letters == DIP_WORD;
                parser.prefix_count   = 2'd0;
                parser.prefix_letters = 24'd0;
                if (dip_line)
                begin
                    parser.in_snippet = 1'b1;
                    if (parser.field_number == wanted_shadow)
                    begin
                        parser.chars_sent = 8'd0;
                        r.kind            = KIND_DISCARD;
                    end
                end
                else if (parser.field_number == wanted_shadow)
                begin
                    r.kind     = KIND_FIELD_END;
                    ends_query = 1'b1;
                end
                else
                    parser.field_number = parser.field_number + 8'd1;
            end
            else
            begin
                if (parser.prefix_count != PREFIX_FULL)
                begin
                    parser.prefix_letters = {parser.prefix_letters[15:0], b};
                    parser.prefix_count   = parser.prefix_count + 2'd1;
                end
                if (parser.field_number == wanted_shadow)
                begin
                    parser.chars_sent = parser.chars_sent + 8'd1;
                    r.kind            = KIND_CHAR;
                    r.ch              = b;
                end
            end
        end
        if (ends_query)
        begin
            parser.finished   = 1'b1;
            parser.in_snippet = 1'b0;
        end
        r.snippet = parser.in_snippet;
        return r;
    endfunction

    // Shadow of the wanted field register
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wanted_shadow <= 8'd0;
        else if (cfg_we)
            wanted_shadow <= cfg_wdata;
    end

    // Request driver; predicts the result of each accepted request
    always @(posedge clk or negedge rst_n)
    begin
        char_req_t nxt;
        if (!rst_n)
        begin
            parser            = STATE_CLEAR;
            src_if.valid       <= 1'b0;
            src_if.char_in     <= 8'd0;
            src_if.query_start <= 1'b0;
        end
        else
        begin
            if (src_if.valid && src_if.ready)
                pending_results.push_back(parse_byte(src_if.char_in, src_if.query_start));
            if (!src_if.valid || src_if.ready)
            begin
                if (char_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = char_reqs.pop_front();
                    src_if.valid       <= 1'b1;
                    src_if.char_in     <= nxt.ch;
                    src_if.query_start <= nxt.first;
                end
                else
                    src_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with none expected: kind %0d char %h snippet %b",
                             $time, res_if.result_kind, res_if.char_out,
                             res_if.next_from_snippet);
                    err_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (res_if.result_kind !== exp_r.kind)
                    begin
                        $display("%0t: result_kind expected %0d actual %0d",
                                 $time, exp_r.kind, res_if.result_kind);
                        err_count++;
                    end
                    if (res_if.char_out !== exp_r.ch)
                    begin
                        $display("%0t: char_out expected %h actual %h",
                                 $time, exp_r.ch, res_if.char_out);
                        err_count++;
                    end
                    if (res_if.next_from_snippet !== exp_r.snippet)
                    begin
                        $display("%0t: next_from_snippet expected %b actual %b",
                                 $time, exp_r.snippet, res_if.next_from_snippet);
                        err_count++;
                    end
                end
            end
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Queue one request; the first after a new query carries query_start
    task automatic push_req(input logic [7:0] b);
        char_reqs.push_back('{ch: b, first: next_is_first});
        next_is_first = 1'b0;
        queued_count++;
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] v;
        do
            v = 8'($urandom_range(1, 254));
        while (v == CHAR_SEMI);
        return v;
    endfunction

    // Spliced snippet: a few fields, closed by a zero (rarely by 0xff)
    task automatic build_snippet();
        int nsnip;
        nsnip = $urandom_range(1, 3);
        for (int s = 0; s < nsnip; s++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                // DIP inside a snippet is plain text
                push_req(DIP_WORD[23:16]);
                push_req(DIP_WORD[15:8]);
                push_req(DIP_WORD[7:0]);
            end
            repeat ($urandom_range(0, 4)) push_req(text_char());
            if (s != nsnip - 1 || $urandom_range(0, 1) == 0)
                push_req(CHAR_SEMI);
        end
        push_req(($urandom_range(0, 9) == 0) ? CHAR_FF : CHAR_NUL);
    endtask

    // One query aimed at field w
    task automatic build_query(input int w);
        int nfield;
        int flen;
        int sel;
        nfield        = w + $urandom_range(0, 3);
        next_is_first = 1'b1;
        for (int f = 0; f < nfield; f++)
        begin
            sel = (w > 20) ? $urandom_range(3, 9) : $urandom_range(0, 9);
            if (sel < 3)
            begin
                push_req(DIP_WORD[23:16]);
                push_req(DIP_WORD[15:8]);
                if (sel < 2)
                    push_req(DIP_WORD[7:0]);
                flen = $urandom_range(0, 3);
            end
            else if (f == w && $urandom_range(0, 5) == 0)
                flen = $urandom_range(CHAR_CAP - 8, CHAR_CAP + 12);
            else if (w > 20)
                flen = $urandom_range(0, 1);
            else
                flen = $urandom_range(0, 6);
            repeat (flen) push_req(text_char());
            push_req(CHAR_SEMI);
            if (sel < 2)
                build_snippet();
        end
        // terminator: zero, 0xff or missing
        sel = $urandom_range(0, 3);
        if (sel < 2)
            push_req(CHAR_NUL);
        else if (sel == 2)
            push_req(CHAR_FF);
        repeat ($urandom_range(0, 2)) push_req(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (char_reqs.size() != 0 || src_if.valid || pending_results.size() != 0);
    endtask

    task automatic write_wanted(input logic [7:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Stimulus and end of run
    initial
    begin
        int         ph;
        int         goal;
        int         half;
        int         sel;
        int         wanted;
        bit         paused;
        logic [7:0] directed[$];
        int         phase_wanted[NUM_PHASES];
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = 8'd0;
        src_if.valid       = 1'b0;
        src_if.char_in     = 8'd0;
        src_if.query_start = 1'b0;
        res_if.ready       = 1'b0;
        send_idle_pct      = 11;
        recv_idle_pct      = 69;
        err_count          = 0;
        queued_count       = 0;
        next_is_first      = 1'b0;
        phase_wanted       = '{0, 1, 255, 2, -1, 3, 0, -1, 1};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, wanted field at its reset value 0.
        // Bytes right after reset, without query start
        push_req("A");
        push_req(CHAR_SEMI);
        push_req("x");
        // no-config markers
        next_is_first = 1'b1;
        push_req(CHAR_FF);
        next_is_first = 1'b1;
        push_req(CHAR_A4);
        // wanted DIP line, snippet, back to main, field end
        next_is_first = 1'b1;
        directed = '{DIP_WORD[23:16], DIP_WORD[15:8], DIP_WORD[7:0], CHAR_SEMI,
                     "k", CHAR_NUL, CHAR_SEMI};
        foreach (directed[i]) push_req(directed[i]);
        // zero as first byte, empty field
        next_is_first = 1'b1;
        push_req(CHAR_NUL);
        next_is_first = 1'b1;
        push_req(CHAR_SEMI);
        // extreme text bytes, then 0xff mid-stream, then ignored bytes
        next_is_first = 1'b1;
        directed = '{8'h01, 8'hFE, CHAR_A4, 8'h80, CHAR_FF, 8'h7F, CHAR_NUL};
        foreach (directed[i]) push_req(directed[i]);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            case (ph / 3)
                0: begin send_idle_pct = 11; recv_idle_pct = 69; end
                1: begin send_idle_pct = 69; recv_idle_pct = 11; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            wanted = (phase_wanted[ph] < 0) ? $urandom_range(0, 8) : phase_wanted[ph];
            write_wanted(8'(wanted));
            goal   = queued_count + PHASE_ITEMS;
            half   = queued_count + PHASE_ITEMS / 2;
            paused = 1'b0;
            do
            begin
                sel = $urandom_range(0, 19);
                if (wanted > 20 || sel > 2)
                    build_query(wanted);
                else if (sel == 2)
                begin
                    // no config string
                    next_is_first = 1'b1;
                    push_req(($urandom_range(0, 1) == 0) ? CHAR_FF : CHAR_A4);
                    repeat ($urandom_range(0, 2)) push_req(8'($urandom_range(0, 255)));
                end
                else
                begin
                    // raw noise query
                    next_is_first = 1'b1;
                    repeat ($urandom_range(1, 8)) push_req(8'($urandom_range(0, 255)));
                end
                // hold the sender until every result is back
                if (!paused && queued_count >= half)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            while (queued_count < goal);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/cfe_pkg.sv
rtl/cfe_ifs.sv
rtl/cfe_parser.sv
rtl/config_field_extractor.sv
rtl/cfe_checker.sv
sim/config_field_extractor_tb.sv
